// File: rtl/core/json_string_escaper_defines.svh
// ----------------------------------------------------------------------------
// JSON string escaper assertion macros
// Assertion wrappers shared by the escaper modules; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge once reset is released.
`define JSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define JSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSE_ASSERT(label, prop, msg)
`define JSE_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/core/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character codes and helpers shared by the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_UNIT  = 2'd1,
    ACT_END   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // How the back end expands one queued word.
  typedef enum logic [1:0] {
    KIND_ONE  = 2'd0, // the unit itself
    KIND_PAIR = 2'd1, // backslash, then the unit
    KIND_SIX  = 2'd2  // backslash, u, four hex digits of the unit
  } kind_t;

  localparam int UnitW = 16;

  typedef struct packed {
    kind_t            kind;
    logic [UnitW-1:0] unit;
  } desc_t;

  // Step counter across the up to six units of one word.
  localparam int StepW     = 3;
  localparam int QueueDepth = 4;

  // Configuration port.
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam logic REG_ESCAPE_UNICODE = 1'b0;

  localparam logic [UnitW-1:0] CH_QUOTE   = 16'h0022;
  localparam logic [UnitW-1:0] CH_BSLASH  = 16'h005C;
  localparam logic [UnitW-1:0] CH_BS      = 16'h0008;
  localparam logic [UnitW-1:0] CH_FF      = 16'h000C;
  localparam logic [UnitW-1:0] CH_LF      = 16'h000A;
  localparam logic [UnitW-1:0] CH_CR      = 16'h000D;
  localparam logic [UnitW-1:0] CH_TAB     = 16'h0009;
  localparam logic [UnitW-1:0] CH_LOWER_B = 16'h0062;
  localparam logic [UnitW-1:0] CH_LOWER_F = 16'h0066;
  localparam logic [UnitW-1:0] CH_LOWER_N = 16'h006E;
  localparam logic [UnitW-1:0] CH_LOWER_R = 16'h0072;
  localparam logic [UnitW-1:0] CH_LOWER_T = 16'h0074;
  localparam logic [UnitW-1:0] CH_LOWER_U = 16'h0075;
  localparam logic [UnitW-1:0] CH_SPACE   = 16'h0020;
  localparam logic [UnitW-1:0] CH_TILDE   = 16'h007E;
  localparam logic [UnitW-1:0] CH_PASS_LO = 16'h00A1;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [UnitW-1:0] hex_char(input logic [3:0] nibble);
    return {8'h00, HEX_DIGITS[nibble]};
  endfunction

endpackage

// File: rtl/core/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Holds the configuration register and classifies each accepted item into a
// queue word for the back end.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     in_action,
  input  logic [jse_pkg::UnitW-1:0]      in_code_unit,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jse_pkg::AddrW-1:0]      paddr,
  input  logic [jse_pkg::DataW-1:0]      pwdata,
  output logic [jse_pkg::DataW-1:0]      prdata,
  output logic                           push,
  output jse_pkg::desc_t                 push_desc
);

  logic escape_unicode_r;
  logic escape_unicode_nxt;
  logic reg_sel;
  logic cfg_write;
  logic accept;

  assign reg_sel   = (paddr[jse_pkg::AddrW-1:2] == jse_pkg::REG_ESCAPE_UNICODE);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    escape_unicode_nxt = escape_unicode_r;
    if (cfg_write && reg_sel) begin
      escape_unicode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_unicode_r <= 1'b0;
    end else begin
      escape_unicode_r <= escape_unicode_nxt;
    end
  end

  assign prdata = {{(jse_pkg::DataW-1){1'b0}}, escape_unicode_r && reg_sel};

  assign accept = start && !busy;

  // Classification of one item; an unused action code yields nothing.
  always_comb begin
    logic [jse_pkg::UnitW-1:0] u;
    logic                      above;
    u              = in_code_unit;
    above          = (u > jse_pkg::CH_TILDE);
    push           = 1'b0;
    push_desc.kind = jse_pkg::KIND_ONE;
    push_desc.unit = jse_pkg::CH_QUOTE;
    unique case (jse_pkg::action_t'(in_action))
      jse_pkg::ACT_BEGIN, jse_pkg::ACT_END: begin
        push = accept;
      end
      jse_pkg::ACT_UNIT: begin
        push = accept;
        case (u)
          jse_pkg::CH_QUOTE: begin
            push_desc.kind = jse_pkg::KIND_PAIR;
            push_desc.unit = jse_pkg::CH_QUOTE;
          end
          jse_pkg::CH_BSLASH: begin
            push_desc.kind = jse_pkg::KIND_PAIR;
            push_desc.unit = jse_pkg::CH_BSLASH;
          end
          jse_pkg::CH_BS: begin
            push_desc.kind = jse_pkg::KIND_PAIR;
            push_desc.unit = jse_pkg::CH_LOWER_B;
          end
          jse_pkg::CH_FF: begin
            push_desc.kind = jse_pkg::KIND_PAIR;
            push_desc.unit = jse_pkg::CH_LOWER_F;
          end
          jse_pkg::CH_LF: begin
            push_desc.kind = jse_pkg::KIND_PAIR;
            push_desc.unit = jse_pkg::CH_LOWER_N;
          end
          jse_pkg::CH_CR: begin
            push_desc.kind = jse_pkg::KIND_PAIR;
            push_desc.unit = jse_pkg::CH_LOWER_R;
          end
          jse_pkg::CH_TAB: begin
            push_desc.kind = jse_pkg::KIND_PAIR;
            push_desc.unit = jse_pkg::CH_LOWER_T;
          end
          default: begin
            push_desc.unit = u;
            if ((u < jse_pkg::CH_SPACE) ||
                (above && (escape_unicode_r || (u < jse_pkg::CH_PASS_LO)))) begin
              push_desc.kind = jse_pkg::KIND_SIX;
            end else begin
              push_desc.kind = jse_pkg::KIND_ONE;
            end
          end
        endcase
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/jse_queue.sv
// ----------------------------------------------------------------------------
// jse_queue
// Small first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
`include "json_string_escaper_defines.svh"

module jse_queue #(
  parameter int DEPTH = jse_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jse_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output jse_pkg::desc_t head_desc
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  jse_pkg::desc_t entry_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (count_r == CntW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  `JSE_ASSERT(a_no_push_when_full, push |-> !full, "word pushed into a full queue")
  `JSE_ASSERT(a_no_pop_when_empty, pop |-> head_valid, "pop from an empty queue")
  `JSE_ASSERT(a_count_in_range, count_r <= CntW'(DEPTH), "queue count overflow")

endmodule

// File: rtl/core/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Expands each queued word into one to six output units into a registered
// output stage, one per cycle while a word is queued.
// ----------------------------------------------------------------------------
`include "json_string_escaper_defines.svh"

module jse_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  jse_pkg::desc_t            head_desc,
  output logic                      pop,
  output logic                      out_strobe,
  output logic [jse_pkg::UnitW-1:0] out_char,
  output logic                      out_last
);

  logic [jse_pkg::StepW-1:0] step_r, step_nxt;
  logic                      strobe_r, strobe_nxt;
  logic [jse_pkg::UnitW-1:0] char_r, char_nxt;
  logic                      last_r, last_nxt;
  logic                      is_last;
  logic [jse_pkg::UnitW-1:0] cur_char;

  always_comb begin
    is_last  = 1'b1;
    cur_char = head_desc.unit;
    case (head_desc.kind)
      jse_pkg::KIND_PAIR: begin
        is_last  = (step_r == jse_pkg::StepW'(1));
        cur_char = (step_r == '0) ? jse_pkg::CH_BSLASH : head_desc.unit;
      end
      jse_pkg::KIND_SIX: begin
        is_last = (step_r == jse_pkg::StepW'(5));
        case (step_r)
          3'd0:    cur_char = jse_pkg::CH_BSLASH;
          3'd1:    cur_char = jse_pkg::CH_LOWER_U;
          3'd2:    cur_char = jse_pkg::hex_char(head_desc.unit[15:12]);
          3'd3:    cur_char = jse_pkg::hex_char(head_desc.unit[11:8]);
          3'd4:    cur_char = jse_pkg::hex_char(head_desc.unit[7:4]);
          default: cur_char = jse_pkg::hex_char(head_desc.unit[3:0]);
        endcase
      end
      default: begin
        is_last  = 1'b1;
        cur_char = head_desc.unit;
      end
    endcase
  end

  assign pop = head_valid && is_last;

  always_comb begin
    step_nxt   = step_r;
    strobe_nxt = head_valid;
    char_nxt   = cur_char;
    last_nxt   = is_last;
    if (head_valid) begin
      step_nxt = is_last ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_char   = char_r;
  assign out_last   = last_r;

  // A word in the middle of its expansion stays at the head of the queue.
  `JSE_ASSERT(a_mid_word_has_head, (step_r != '0) |-> head_valid, "expansion lost its word")
  `JSE_ASSERT(a_last_resets_step, (strobe_r && last_r) |-> (step_r == '0),
              "step counter not cleared after a final unit")
  `JSE_ASSERT(a_step_bound, step_r <= jse_pkg::StepW'(5), "step counter out of range")

endmodule

// File: rtl/core/json_string_escaper.sv
// ----------------------------------------------------------------------------
// json_string_escaper
// Turns a framed stream of 16-bit code units into a JSON string literal.
// ----------------------------------------------------------------------------
//  Channel   Ports                                      Handshake
//  input     start, busy, in_action, in_code_unit       start & !busy
//  result    out_strobe, out_char, out_last             out_strobe, no stall
//  config    psel, penable, pwrite, paddr, pwdata,      APB write, pready = 1
//            prdata, pready
//
// The back end emits one unit per cycle while a word is queued: one unit per
// plain unit or quote, two per short escape and six per \uXXXX escape; that
// sequencer sets the rate. Results pass the queue, then the output register.
// busy is high while the four-entry word queue between front and back is full.
// Reset is synchronous and active low; it clears the register to 0 and empties
// the queue. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module json_string_escaper #(
  parameter int QUEUE_DEPTH = jse_pkg::QueueDepth
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic [jse_pkg::UnitW-1:0] in_code_unit,
  output logic                      out_strobe,
  output logic [jse_pkg::UnitW-1:0] out_char,
  output logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [jse_pkg::AddrW-1:0] paddr,
  input  logic [jse_pkg::DataW-1:0] pwdata,
  output logic [jse_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  logic           push;
  jse_pkg::desc_t push_desc;
  logic           pop;
  logic           full;
  logic           head_valid;
  jse_pkg::desc_t head_desc;

  assign busy   = full;
  assign pready = 1'b1;

  jse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (full),
    .in_action    (in_action),
    .in_code_unit (in_code_unit),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .push         (push),
    .push_desc    (push_desc)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_char   (out_char),
    .out_last   (out_last)
  );

endmodule

// File: bench/tb_json_string_escaper.sv
// ----------------------------------------------------------------------------
// tb_json_string_escaper
// Self-checking bench for the JSON string escaper. Items are sent in random
// bursts. Every accepted item is expanded into the code units it should
// produce, and each output word is checked against the oldest one waiting.
// The escape-unicode register is changed over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_json_string_escaper;
  timeunit 1ns;
  timeprecision 1ps;

  import jse_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam logic [AddrW-1:0] EscAddr = AddrW'(4 * int'(REG_ESCAPE_UNICODE));
  localparam logic [AddrW-1:0] NoRegAddr = AddrW'(4 * (int'(REG_ESCAPE_UNICODE) + 1));
  localparam logic [UnitW-1:0] AsciiZero = 16'h0030;
  localparam logic [UnitW-1:0] AsciiUpperA = 16'h0041;
  localparam logic [UnitW-1:0] ShortEscapes [7] = '{
    CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB
  };

  typedef struct packed {
    logic [UnitW-1:0] ch;
    logic             last;
  } json_word_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_action;
  logic [UnitW-1:0] in_code_unit;
  logic             out_strobe;
  logic [UnitW-1:0] out_char;
  logic             out_last;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  json_word_t expected_words [$];
  logic       escape_all_model;
  int         fail_count;
  int         quiet_cycles;
  int         burst_left;

  json_string_escaper i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_code_unit(in_code_unit),
    .out_strobe  (out_strobe),
    .out_char    (out_char),
    .out_last    (out_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Expands one item into the JSON code units it must produce.
  function automatic void predict_escape(input action_t act, input logic [UnitW-1:0] unit);
    logic [UnitW-1:0] seq [$];
    logic [UnitW-1:0] pair_ch;
    logic [3:0]       nib;
    bit               six;
    json_word_t       w;
    pair_ch = '0;
    case (act)
      ACT_BEGIN, ACT_END: seq.push_back(CH_QUOTE);
      ACT_UNIT: begin
        case (unit)
          CH_QUOTE:  pair_ch = CH_QUOTE;
          CH_BSLASH: pair_ch = CH_BSLASH;
          CH_BS:     pair_ch = CH_LOWER_B;
          CH_FF:     pair_ch = CH_LOWER_F;
          CH_LF:     pair_ch = CH_LOWER_N;
          CH_CR:     pair_ch = CH_LOWER_R;
          CH_TAB:    pair_ch = CH_LOWER_T;
          default:   pair_ch = '0;
        endcase
        if (escape_all_model) begin
          six = (unit < CH_SPACE) || (unit > CH_TILDE);
        end else begin
          six = (unit < CH_SPACE) || (unit > CH_TILDE && unit < CH_PASS_LO);
        end
        if (pair_ch != '0) begin
          seq.push_back(CH_BSLASH);
          seq.push_back(pair_ch);
        end else if (six) begin
          seq.push_back(CH_BSLASH);
          seq.push_back(CH_LOWER_U);
          for (int i = 3; i >= 0; i--) begin
            nib = unit[4*i +: 4];
            seq.push_back(nib < 4'd10 ? AsciiZero + nib : AsciiUpperA + nib - 16'd10);
          end
        end else begin
          seq.push_back(unit);
        end
      end
      default: ;
    endcase
    foreach (seq[k]) begin
      w.ch = seq[k];
      w.last = (k == seq.size() - 1);
      expected_words.push_back(w);
    end
  endfunction

  // Registers accepted items and config writes, and checks every output word.
  always @(posedge clk) begin : monitor
    json_word_t want;
    if (rst_n) begin
      if (psel && penable && pready && paddr == EscAddr) begin
        if (pwrite) begin
          escape_all_model = pwdata[0];
        end else if (prdata !== DataW'(escape_all_model)) begin
          $error("prdata: expected %0h, actual %0h", DataW'(escape_all_model), prdata);
          fail_count++;
        end
      end
      if (start && !busy) begin
        predict_escape(action_t'(in_action), in_code_unit);
      end
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          $error("out_char: no word expected, actual %0h", out_char);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %0h, actual %0h", want.ch, out_char);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe || (psel && penable)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_json_string_escaper failed");
        $finish;
      end
    end
  end

  // Sends one item; between bursts of random length the sender may idle.
  task automatic send_item(input action_t act, input logic [UnitW-1:0] unit);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    start        <= 1'b1;
    in_action    <= act;
    in_code_unit <= unit;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending until every expected word has come out, then stays idle.
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed_units();
    logic [UnitW-1:0] units [$] = '{
      16'h0000, 16'hFFFF, CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB,
      16'h001F, CH_SPACE, 16'h0041, CH_TILDE, 16'h007F, 16'h00A0, CH_PASS_LO
    };
    // The code unit of a begin or end word must be ignored.
    send_item(ACT_BEGIN, 16'hFFFF);
    foreach (units[k]) send_item(ACT_UNIT, units[k]);
    send_item(ACT_NONE, 16'hFFFF);
    send_item(ACT_END, 16'hA5A5);
    send_item(ACT_END, 16'h0000);
    send_item(ACT_UNIT, CH_BSLASH);
    send_item(ACT_BEGIN, 16'h0000);
    send_item(ACT_BEGIN, 16'h0022);
    drain();
  endtask

  task automatic test_escape_modes();
    logic [UnitW-1:0] units [$] = '{CH_TILDE, 16'h007F, 16'h00A0, CH_PASS_LO, 16'h8000,
                                    16'hFFFF};
    for (int mode = 1; mode >= 0; mode--) begin
      cfg_access(1'b1, EscAddr, mode ? 32'h8000_0001 : 32'hFFFF_FFFE);
      // A write past the last register must leave the flag alone.
      cfg_access(1'b1, NoRegAddr, mode ? 32'h0 : 32'h1);
      cfg_access(1'b0, EscAddr, '0);
      send_item(ACT_BEGIN, 16'h0);
      foreach (units[k]) send_item(ACT_UNIT, units[k]);
      send_item(ACT_END, 16'h0);
      drain();
    end
  endtask

  task automatic test_random_text();
    int               sent;
    int               len;
    logic [UnitW-1:0] unit;
    for (int phase = 0; phase < 6; phase++) begin
      cfg_access(1'b1, EscAddr, {31'($urandom()), 1'(phase % 2)});
      cfg_access(1'b0, EscAddr, '0);
      sent = 0;
      while (sent < 65) begin
        if ($urandom_range(0, 9) < 8) begin
          len = $urandom_range(0, 12);
          send_item(ACT_BEGIN, 16'($urandom()));
          repeat (len) begin
            case ($urandom_range(0, 9))
              0, 1, 2: unit = 16'($urandom_range(CH_SPACE, CH_TILDE));
              3:       unit = ShortEscapes[$urandom_range(0, 6)];
              4:       unit = 16'($urandom_range(0, CH_SPACE - 1));
              5:       unit = 16'($urandom_range(16'h007F, CH_PASS_LO));
              6, 7:    unit = 16'($urandom_range(CH_PASS_LO, 16'hFFFF));
              default: unit = 16'($urandom());
            endcase
            send_item(ACT_UNIT, unit);
          end
          // Now and then a string is cut off without its closing word.
          if ($urandom_range(0, 7) != 0) send_item(ACT_END, 16'($urandom()));
          sent += len + 2;
        end else begin
          send_item(action_t'($urandom_range(0, 3)), 16'($urandom()));
          sent++;
        end
        if (phase == 2 && sent > 35 && sent < 40) drain();
      end
      drain();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = ACT_NONE;
    in_code_unit = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    escape_all_model = 1'b0;
    fail_count   = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_units();
    test_escape_modes();
    test_random_text();

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("tb_json_string_escaper passed");
    end else begin
      $display("tb_json_string_escaper failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/jse_pkg.sv
rtl/core/jse_front.sv
rtl/core/jse_queue.sv
rtl/core/jse_back.sv
rtl/core/json_string_escaper.sv
bench/tb_json_string_escaper.sv
